>>> rtl/ssmt_pkg.sv
package ssmt_pkg;

  typedef enum logic [1:0] {
    REQ_FIND = 2'd0,
    REQ_ADD  = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMATCH  = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNFILLED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_HREAD,
    S_RESP
  } state_e;

  localparam int unsigned MODE_W      = 24;
  localparam int unsigned LOD_W       = 19;
  localparam int unsigned MAXK_W      = 20;
  localparam int unsigned MINK_W      = 21;
  localparam int unsigned HANDLE_W    = 64;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [9:0]  LOD_SCALE   = 10'd1000;
  localparam logic [17:0] MAX_LOD_RAW = 18'd256000;

  typedef struct packed {
    logic [MAXK_W-1:0] max_k;
    logic [MODE_W-1:0] modes;
  } key_t;

  typedef struct packed {
    logic [MINK_W-1:0] min_k;
    key_t              key;
  } entry_t;

endpackage

>>> rtl/ssmt_keygen.sv
module ssmt_keygen import ssmt_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [MODE_W-1:0] modes_i,
  input  logic [LOD_W-1:0] min_lod_i,
  input  logic [LOD_W-1:0] max_lod_i,
  output key_t             key_o,
  output logic [MINK_W-1:0] min_k_o
);

  logic [LOD_W-1:0]    min_mag;
  logic [28:0]         min_prod;
  logic [MINK_W-1:0]   min_quo;
  logic [MINK_W-1:0]   min_k_d;
  logic [17:0]         max_cl;
  logic [27:0]         max_prod;
  key_t                key_d;
  key_t                key_q;
  logic [MINK_W-1:0]   min_k_q;

  // thousandths = trunc(raw * 1000 / 256); min: sign applied to the magnitude, max: clamped to 0..256000 raw first
  always_comb begin
    min_mag  = min_lod_i[LOD_W-1] ? LOD_W'(-min_lod_i) : min_lod_i;
    min_prod = 29'(min_mag) * 29'(LOD_SCALE);
    min_quo  = min_prod[28:8];
    min_k_d  = min_lod_i[LOD_W-1] ? MINK_W'(-min_quo) : min_quo;

    if (max_lod_i[LOD_W-1]) begin
      max_cl = '0;
    end else if (max_lod_i[17:0] > MAX_LOD_RAW) begin
      max_cl = MAX_LOD_RAW;
    end else begin
      max_cl = max_lod_i[17:0];
    end
    max_prod    = 28'(max_cl) * 28'(LOD_SCALE);
    key_d.max_k = max_prod[27:8];
    key_d.modes = modes_i;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q   <= key_d;
      min_k_q <= min_k_d;
    end
  end

  assign key_o   = key_q;
  assign min_k_o = min_k_q;

endmodule

>>> rtl/ssmt_store.sv
module ssmt_store import ssmt_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic                re_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] addr_i,
  input  entry_t              wentry_i,
  input  logic [HANDLE_W-1:0] whandle_i,
  output entry_t              rentry_o,
  output logic [HANDLE_W-1:0] rhandle_o
);

  entry_t              entry_mem  [CAPACITY];
  logic [HANDLE_W-1:0] handle_mem [CAPACITY];
  entry_t              rentry_q;
  logic [HANDLE_W-1:0] rhandle_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entry_mem[addr_i]  <= wentry_i;
      handle_mem[addr_i] <= whandle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rentry_q  <= entry_mem[addr_i];
      rhandle_q <= handle_mem[addr_i];
    end
  end

  assign rentry_o  = rentry_q;
  assign rhandle_o = rhandle_q;

endmodule

>>> rtl/ssmt_ctrl.sv
module ssmt_ctrl import ssmt_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  req_e                s_req_i,
  input  logic [HANDLE_W-1:0] s_handle_i,
  input  logic [SLOT_W-1:0]   s_slot_i,
  output logic                load_o,
  input  key_t                key_i,
  input  logic [MINK_W-1:0]   min_k_i,
  input  entry_t              rentry_i,
  input  logic [HANDLE_W-1:0] rhandle_i,
  output logic                mem_we_o,
  output logic                mem_re_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_addr_o,
  output entry_t              wentry_o,
  output logic [HANDLE_W-1:0] whandle_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output status_e             m_status_o,
  output logic [SLOT_W-1:0]   m_slot_o,
  output logic [HANDLE_W-1:0] m_handle_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       idx_q, idx_d;
  req_e                req_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [SLOT_W-1:0]   slot_q;
  status_e             res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic                out_load;
  logic                full;
  logic                slot_filled;
  logic                scan_last;
  logic                scan_hit;
  entry_t              want;

  assign want.min_k  = min_k_i;
  assign want.key    = key_i;
  assign full        = (count_q == CW'(CAPACITY));
  assign slot_filled = (32'(slot_q) < 32'(count_q));
  assign scan_last   = ((32'(idx_q) + 32'd1) == 32'(count_q));
  assign scan_hit    = (rentry_i == want);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_handle_d = res_handle_q;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;
    mem_addr_o   = idx_q;
    s_ready_o    = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        res_status_d = ST_OK;
        res_slot_d   = '0;
        res_handle_d = '0;
        state_d      = S_RESP;
        unique case (req_q)
          REQ_FIND: begin
            if (count_q == '0) begin
              res_status_d = ST_NOMATCH;
            end else begin
              mem_re_o   = 1'b1;
              mem_addr_o = '0;
              idx_d      = '0;
              state_d    = S_SCAN;
            end
          end
          REQ_ADD: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              mem_we_o   = 1'b1;
              mem_addr_o = count_q[AW-1:0];
              count_d    = count_q + 1'b1;
              res_slot_d = SLOT_W'(count_q[AW-1:0]);
            end
          end
          REQ_READ: begin
            res_slot_d = slot_q;
            if (slot_filled) begin
              mem_re_o   = 1'b1;
              mem_addr_o = AW'(slot_q);
              state_d    = S_HREAD;
            end else begin
              res_status_d = ST_UNFILLED;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        priority if (scan_hit) begin
          res_slot_d = SLOT_W'(idx_q);
          state_d    = S_RESP;
        end else if (scan_last) begin
          res_status_d = ST_NOMATCH;
          state_d      = S_RESP;
        end else begin
          mem_re_o   = 1'b1;
          mem_addr_o = idx_q + 1'b1;
          idx_d      = idx_q + 1'b1;
        end
      end
      S_HREAD: begin
        res_handle_d = rhandle_i;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || m_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign load_o      = s_valid_i && s_ready_o;
  assign out_valid_d = out_load || (out_valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_handle_q <= res_handle_d;
    if (load_o) begin
      req_q    <= s_req_i;
      handle_q <= s_handle_i;
      slot_q   <= s_slot_i;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_handle_q <= res_handle_q;
    end
  end

  assign wentry_o   = want;
  assign whandle_o  = handle_q;
  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_slot_o   = out_slot_q;
  assign m_handle_o = out_handle_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("entry count beyond capacity");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> !full && state_q == S_CONV && req_q == REQ_ADD)
    else $error("write into a full table or outside an add");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV && req_q == REQ_ADD && !full) |=>
      count_q == $past(count_q) + 1'b1)
    else $error("add did not advance the count");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> 32'(idx_q) < 32'(count_q))
    else $error("scan beyond filled slots");

  a_accept_to_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |=> state_q == S_CONV)
    else $error("accepted beat not processed");

endmodule

>>> rtl/sampler_state_match_table.sv
// channel   dir  tdata                                        tuser
// s_axis    in   see port comment (136 bits)                  req_type
// m_axis    out  slot_index, handle_out (72 bits)             status
//
// add, unused request, unfilled read, find on empty table: result: S_CONV, S_RESP
// filled read: S_CONV, S_HREAD, S_RESP; find: S_SCAN compares n filled slots, one per
//   cycle through the single read port of the entry memory (up to CAPACITY), then S_RESP
// s_axis is ready again in the cycle after the result is loaded into the output register
// reset clears the fill count and the handshake state; memories are not cleared
// a stalled m_axis holds up the block only while a second result waits
module sampler_state_match_table import ssmt_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // minify mode, magnify mode, wrap_u, wrap_v, wrap_w, anisotropy limit,
  // border colour code, min_lod, max_lod, handle, slot_select, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // slot_index, handle_out, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]             m_axis_tuser
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                load;
  key_t                key;
  logic [MINK_W-1:0]   min_k;
  entry_t              rentry;
  logic [HANDLE_W-1:0] rhandle;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_addr;
  entry_t              wentry;
  logic [HANDLE_W-1:0] whandle;
  status_e             m_status;
  logic [SLOT_W-1:0]   m_slot;
  logic [HANDLE_W-1:0] m_handle;

  ssmt_keygen u_keygen (
    .clk_i     (clk_i),
    .load_i    (load),
    .modes_i   (s_axis_tdata[23:0]),
    .min_lod_i (s_axis_tdata[42:24]),
    .max_lod_i (s_axis_tdata[61:43]),
    .key_o     (key),
    .min_k_o   (min_k)
  );

  ssmt_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .re_i      (mem_re),
    .addr_i    (mem_addr),
    .wentry_i  (wentry),
    .whandle_i (whandle),
    .rentry_o  (rentry),
    .rhandle_o (rhandle)
  );

  ssmt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_req_i    (req_e'(s_axis_tuser)),
    .s_handle_i (s_axis_tdata[125:62]),
    .s_slot_i   (s_axis_tdata[131:126]),
    .load_o     (load),
    .key_i      (key),
    .min_k_i    (min_k),
    .rentry_i   (rentry),
    .rhandle_i  (rhandle),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .wentry_o   (wentry),
    .whandle_o  (whandle),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_status_o (m_status),
    .m_slot_o   (m_slot),
    .m_handle_o (m_handle)
  );

  assign m_axis_tdata = {2'b00, m_handle, m_slot};
  assign m_axis_tuser = m_status;

endmodule
